### rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_INIT    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NULL_REL  = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_TBL_FULL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_HEAP_START = 2'd0,
    CFG_HEAP_LIMIT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_CHECK,
    BK_BUMP,
    BK_DONE
  } bk_state_e;

  // classified command between front and back
  typedef struct packed {
    op_e         op;
    logic        zero;      // alloc of size 0 or release of null
    logic [32:0] size;      // rounded alloc size, 33 bits
    logic [31:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
    logic [31:0] used;
  } res_t;

endpackage
`default_nettype wire

### rtl/ffha_ram.sv
`default_nettype none
module ffha_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/ffha_front.sv
`default_nettype none
module ffha_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  wire [1:0]           opcode_i,
  input  wire [31:0]          request_size_i,
  input  wire [31:0]          release_address_i,
  output logic                cmd_valid_o,
  output ffha_pkg::cmd_t      cmd_o,
  input  wire                 cmd_take_i
);
  import ffha_pkg::*;

  // two-entry queue
  cmd_t        slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  cmd_t        cls;
  logic [32:0] rnd;
  logic        do_push, do_pop;

  always_comb begin
    rnd       = ({1'b0, request_size_i} + 33'd3) & ~33'd3;
    cls.op    = op_e'(opcode_i);
    cls.size  = rnd;
    cls.addr  = release_address_i;
    cls.zero  = (opcode_i == OP_ALLOC) ? (request_size_i == '0)
                                       : (release_address_i == '0);
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_take_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

### rtl/ffha_back.sv
`default_nettype none
module ffha_back #(
  parameter int MaxBlocks   = 64,
  parameter int HeaderBytes = 12
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire [31:0]      heap_start_i,
  input  wire [31:0]      heap_limit_i,
  input  wire             cmd_valid_i,
  input  ffha_pkg::cmd_t  cmd_i,
  output logic            cmd_take_o,
  output logic            res_valid_o,
  output ffha_pkg::res_t  res_o,
  input  wire             res_take_i
);
  import ffha_pkg::*;

  localparam int Aw = $clog2(MaxBlocks);
  localparam int Cw = Aw + 1;

  bk_state_e   state_q, state_d;
  cmd_t        cmd_q;
  logic [Cw-1:0] count_q, count_d;
  logic [Cw-1:0] idx_q, idx_d;     // entry+1 being looked at
  logic [31:0] brk_q, brk_d;
  logic [31:0] used_q, used_d;
  logic        hit_q, hit_d;
  logic [Aw-1:0] hit_idx_q, hit_idx_d;
  logic [32:0] need_q, need_d;
  res_t        res_q, res_d;
  logic        res_vld_q, res_vld_d;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic          free_we;
  logic [Aw-1:0] free_addr;
  logic          free_wd;
  logic          rd_free;
  logic [Aw-1:0] rd_idx_q;
  logic [31:0]   rd_pay, rd_bytes;
  logic [33:0]   end_sum;
  logic [32:0]   a_start;

  assign rd_pay   = rdata[63:32];
  assign rd_bytes = rdata[31:0];

  ffha_ram #(.Width(64), .Depth(MaxBlocks)) u_tbl (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // free flags are written only at valid entries
  ffha_ram #(.Width(1), .Depth(MaxBlocks)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(free_addr), .wdata_i(free_wd),
    .raddr_i(raddr), .rdata_o(rd_free)
  );

  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
  end

  assign raddr      = Aw'(idx_q - Cw'(1));
  assign a_start    = ({1'b0, heap_start_i} + 33'd3) & ~33'd3;
  assign end_sum    = {2'b0, brk_q} + {1'b0, need_q};
  assign cmd_take_o = (state_q == BK_IDLE) && cmd_valid_i && !res_vld_q;
  assign res_valid_o = res_vld_q;
  assign res_o      = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (cmd_take_o) begin
        if (cmd_i.op == OP_ALLOC && !cmd_i.zero) state_d = BK_SCAN;
        else if (cmd_i.op == OP_RELEASE && !cmd_i.zero) state_d = BK_SCAN;
        else state_d = BK_DONE;
      end
      BK_SCAN:  state_d = (idx_q == '0) ? BK_CHECK : BK_WAIT;
      BK_WAIT:  state_d = BK_CHECK;
      BK_CHECK: begin
        if (hit_d) state_d = BK_DONE;
        else if (idx_q <= Cw'(1)) begin
          state_d = (cmd_q.op == OP_ALLOC) ? BK_BUMP : BK_DONE;
        end else state_d = BK_WAIT;
      end
      BK_BUMP:  state_d = BK_DONE;
      BK_DONE:  state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    brk_d     = brk_q;
    used_d    = used_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    need_d    = need_q;
    res_d     = res_q;
    res_vld_d = res_vld_q;
    we        = 1'b0;
    waddr     = Aw'(count_q);
    wdata     = {brk_q + 32'(HeaderBytes), cmd_q.size[31:0]};
    free_we   = 1'b0;
    free_addr = hit_idx_q;
    free_wd   = 1'b0;
    if (res_vld_q && res_take_i) res_vld_d = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        idx_d  = count_q;
        hit_d  = 1'b0;
        need_d = cmd_i.size + 33'(HeaderBytes);
      end
      BK_SCAN, BK_WAIT: ;
      BK_CHECK: begin
        if (idx_q != '0) begin
          if (cmd_q.op == OP_ALLOC) begin
            if (rd_free && {1'b0, rd_bytes} >= cmd_q.size) hit_d = 1'b1;
          end else if (rd_pay == cmd_q.addr) begin
            hit_d = 1'b1;
          end
          hit_idx_d = rd_idx_q;
          idx_d     = idx_q - Cw'(1);
        end
        res_d.addr   = '0;
        res_d.status = ST_OK;
        if (hit_d) begin
          free_addr = rd_idx_q;
          if (cmd_q.op == OP_ALLOC) begin
            free_we      = 1'b1;
            free_wd      = 1'b0;
            used_d       = used_q + rd_bytes;
            res_d.addr   = rd_pay;
          end else if (!rd_free) begin
            free_we = 1'b1;
            free_wd = 1'b1;
            used_d  = used_q - rd_bytes;
          end
        end else if (cmd_q.op == OP_RELEASE) begin
          res_d.status = ST_UNKNOWN;
        end
      end
      BK_BUMP: begin
        free_addr = Aw'(count_q);
        if (end_sum > {2'b0, heap_limit_i}) begin
          res_d.status = ST_NO_SPACE;
        end else if (count_q >= Cw'(MaxBlocks)) begin
          res_d.status = ST_TBL_FULL;
        end else begin
          we         = 1'b1;
          free_we    = 1'b1;
          free_wd    = 1'b0;
          res_d.addr = brk_q + 32'(HeaderBytes);
          count_d    = count_q + Cw'(1);
          brk_d      = end_sum[31:0];
          used_d     = used_q + cmd_q.size[31:0];
        end
      end
      BK_DONE: begin
        if (cmd_q.op == OP_INIT) begin
          count_d      = '0;
          used_d       = '0;
          brk_d        = a_start[32] ? 32'hFFFF_FFFF : a_start[31:0];
          res_d.addr   = '0;
          res_d.status = ST_OK;
        end else if (cmd_q.op == OP_NOP) begin
          res_d.addr   = '0;
          res_d.status = ST_OK;
        end else if (cmd_q.zero) begin
          res_d.addr   = '0;
          res_d.status = (cmd_q.op == OP_ALLOC) ? ST_ZERO_SIZE : ST_NULL_REL;
        end
        res_d.used = used_d;
        res_vld_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    hit_idx_q <= hit_idx_d;
    need_q    <= need_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      brk_q     <= '0;
      used_q    <= '0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      brk_q     <= brk_d;
      used_q    <= used_d;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
    end
  end
endmodule
`default_nettype wire

### rtl/first_fit_heap_allocator.sv
`default_nettype none
// channel  | handshake            | payload
// input    | push / full          | opcode_i, request_size_i, release_address_i
// result   | empty / pop          | result_address_o, status_o, used_bytes_o
// config   | cfg_we_i             | cfg_index_i, cfg_wdata_i
// Alloc and release walk the table newest first, one entry at a time
// through the registered table read. Init, no-op and rejected requests
// skip the walk and go straight to the result.
// Reset clears counters and pointers; the table needs no clearing.
// A two-entry queue decouples input; the result register holds until popped
// and the back takes no new beat while it is held.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push,
  output logic       full,
  input  wire [1:0]  opcode_i,
  input  wire [31:0] request_size_i,
  input  wire [31:0] release_address_i,
  output logic       empty,
  input  wire        pop,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o,
  output logic [31:0] used_bytes_o,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_index_i,
  input  wire [31:0] cfg_wdata_i
);
  import ffha_pkg::*;

  logic [31:0] start_q, limit_q;
  logic        cmd_valid, cmd_take, res_valid;
  cmd_t        cmd;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_HEAP_START) start_q <= cfg_wdata_i;
      if (cfg_index_i == CFG_HEAP_LIMIT) limit_q <= cfg_wdata_i;
    end
  end

  ffha_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .opcode_i, .request_size_i, .release_address_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  ffha_back #(.MaxBlocks(MAX_BLOCKS), .HeaderBytes(HEADER_BYTES)) u_back (
    .clk_i, .rst_ni,
    .heap_start_i(start_q), .heap_limit_i(limit_q),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop)
  );

  assign empty            = !res_valid;
  assign result_address_o = res.addr;
  assign status_o         = res.status;
  assign used_bytes_o     = res.used;
endmodule
`default_nettype wire
